/* hw/rtl/temperature_trend_filter_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the temperature trend filter
// Clocked, reset-qualified property wrappers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef TEMPERATURE_TREND_FILTER_MACROS_SVH
`define TEMPERATURE_TREND_FILTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define TTF_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define TTF_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/ttf_pkg.sv */
// ----------------------------------------------------------------------------
// ttf_pkg
// Widths, constants and codes for the temperature trend filter.
// ----------------------------------------------------------------------------
`default_nettype none

package ttf_pkg;

    // Field widths
    localparam int ADC_W   = 12;
    localparam int VREF_W  = 12;
    localparam int TEMP_W  = 11;
    localparam int TREND_W = 2;

    // Product of code and reference, and its scaled quotient
    localparam int PROD_W  = ADC_W + VREF_W;
    localparam int QUOT_W  = PROD_W - 10;

    // Stream payload widths (whole bytes)
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 24;

    // Default window depth
    localparam int WINDOW_DEPTH_DEF = 10;

    // Register reset value
    localparam logic [VREF_W-1:0] VREF_RESET = 12'd3000;

    // Conversion: T = (code * vref - 2856960) / 10240, split as >>10 then /10
    localparam logic [PROD_W-1:0] OFFSET_NUM = 24'd2856960;
    localparam logic [TEMP_W-1:0] TEMP_MAX   = 11'd1100;
    // Quotient (after >>10) at which T reaches 1101
    localparam logic [QUOT_W-1:0] QUOT_CLAMP = 14'd11010;
    // ceil(2^16 / 10); exact for quotients below the clamp point
    localparam int                DIV10_SHIFT = 16;
    localparam logic [12:0]       DIV10_RECIP = 13'd6554;

    // Trend codes
    localparam logic [TREND_W-1:0] TREND_RISING  = 2'd0;
    localparam logic [TREND_W-1:0] TREND_FALLING = 2'd1;
    localparam logic [TREND_W-1:0] TREND_STABLE  = 2'd2;

endpackage

`default_nettype wire

/* hw/rtl/temperature_trend_filter.sv */
// ----------------------------------------------------------------------------
// temperature_trend_filter
// Converts sensor ADC codes to degrees Celsius, keeps a moving average over
// the last WINDOW_DEPTH readings and flags a rising, falling or stable trend.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Ports                       Content
//   --------  ---------  --------------------------  ---------------------------
//   s_        in         s_tvalid s_tready s_tdata   one ADC code per transaction
//   m_        out        m_tvalid m_tready m_tdata   temperature, average, trend
//   cfg_      in         cfg_wen cfg_wdata           reference voltage (mV)
//
// One transaction per cycle is accepted while the output is not stalled;
// it passes the capture, product, conversion, window and result registers.
// The window stage updates the running sum with one add and one subtract.
// Synchronous active-low reset clears the window, the sum and all stage
// valids, and loads the reference with 3000 mV.
// Each stage holds when the next one is full and stalled; a bubble anywhere
// lets the stages before it advance.
//
`default_nettype none

module temperature_trend_filter
    import ttf_pkg::*;
#(
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
) (
    input  wire                 aclk,
    input  wire                 aresetn,

    // tdata: [11:0] adc_code, [15:12] zero
    input  wire                 s_tvalid,
    output logic                s_tready,
    input  wire  [S_DATA_W-1:0] s_tdata,

    // tdata: [10:0] temperature_c, [21:11] window_average, [23:22] trend
    output logic                m_tvalid,
    input  wire                 m_tready,
    output logic [M_DATA_W-1:0] m_tdata,

    input  wire                 cfg_wen,
    input  wire  [VREF_W-1:0]   cfg_wdata
);

`include "temperature_trend_filter_macros.svh"

    // Sum and reciprocal widths follow from the window depth
    localparam int SUM_MAX  = WINDOW_DEPTH * 1100;
    localparam int SUM_W    = $clog2(SUM_MAX + 1);
    localparam int AVG_K    = SUM_W + $clog2(WINDOW_DEPTH);
    localparam int RECIP_W  = AVG_K + 1;
    localparam int RECIP    = ((2 ** AVG_K) + WINDOW_DEPTH - 1) / WINDOW_DEPTH;
    localparam int AVG_PW   = SUM_W + RECIP_W;
    localparam int CMP_W    = TEMP_W + 4;

    // Configuration
    logic [VREF_W-1:0] vref_reg;

    // Stage valids
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic ld0, ld1, ld2, ld3, ld4;

    // Stage payloads
    logic [ADC_W-1:0]  adc_reg;
    logic [PROD_W-1:0] prod_reg;
    logic [TEMP_W-1:0] t2_reg;
    logic [TEMP_W-1:0] t3_reg;
    logic [TEMP_W-1:0] temp_out_reg;
    logic [TEMP_W-1:0] avg_out_reg;
    logic [TREND_W-1:0] trend_out_reg;

    // Window state
    logic [TEMP_W-1:0] window_reg [WINDOW_DEPTH];
    logic [SUM_W-1:0]  sum_reg;
    logic [SUM_W-1:0]  sum_next;

    // Conversion
    logic [PROD_W-1:0] diff;
    logic [QUOT_W-1:0] quot;
    logic [QUOT_W+12:0] div10_prod;
    logic [TEMP_W-1:0] t_next;

    // Average and trend
    logic [AVG_PW-1:0]  avg_prod;
    logic [TEMP_W-1:0]  avg_next;
    logic [CMP_W-1:0]   t_x10, avg_x11, avg_x9;
    logic [TREND_W-1:0] trend_next;

    // ------------------------------------------------------------------
    // Handshake chain: a stage loads when it is empty or being emptied
    // ------------------------------------------------------------------
    always_comb begin
        ld4      = v3_reg && (!v4_reg || m_tready);
        ld3      = v2_reg && (!v3_reg || ld4);
        ld2      = v1_reg && (!v2_reg || ld3);
        ld1      = v0_reg && (!v1_reg || ld2);
        s_tready = !v0_reg || ld1;
        ld0      = s_tvalid && s_tready;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            v0_reg <= ld0 || (v0_reg && !ld1);
            v1_reg <= ld1 || (v1_reg && !ld2);
            v2_reg <= ld2 || (v2_reg && !ld3);
            v3_reg <= ld3 || (v3_reg && !ld4);
            v4_reg <= ld4 || (v4_reg && !m_tready);
        end
    end

    // ------------------------------------------------------------------
    // Reference voltage register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vref_reg <= VREF_RESET;
        end else if (cfg_wen) begin
            vref_reg <= cfg_wdata;
        end
    end

    // ------------------------------------------------------------------
    // Capture the code, then form code * vref
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ld0) begin
            adc_reg <= s_tdata[ADC_W-1:0];
        end
        if (ld1) begin
            prod_reg <= PROD_W'(adc_reg) * PROD_W'(vref_reg);
        end
    end

    // ------------------------------------------------------------------
    // Offset, scale by 1/10240 and clamp to 0..1100
    // ------------------------------------------------------------------
    always_comb begin
        diff       = prod_reg - OFFSET_NUM;
        quot       = diff[PROD_W-1:10];
        div10_prod = (QUOT_W+13)'(quot) * (QUOT_W+13)'(DIV10_RECIP);
        if (prod_reg <= OFFSET_NUM) begin
            t_next = '0;
        end else if (quot >= QUOT_CLAMP) begin
            t_next = TEMP_MAX;
        end else begin
            t_next = div10_prod[DIV10_SHIFT +: TEMP_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld2) begin
            t2_reg <= t_next;
        end
    end

    // ------------------------------------------------------------------
    // Window shift and running sum: drop the oldest, add the newest
    // ------------------------------------------------------------------
    assign sum_next = sum_reg - SUM_W'(window_reg[WINDOW_DEPTH-1]) + SUM_W'(t2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= '0;
            for (int i = 0; i < WINDOW_DEPTH; i++) begin
                window_reg[i] <= '0;
            end
        end else if (ld3) begin
            sum_reg       <= sum_next;
            window_reg[0] <= t2_reg;
            for (int i = 1; i < WINDOW_DEPTH; i++) begin
                window_reg[i] <= window_reg[i-1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ld3) begin
            t3_reg <= t2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Average by reciprocal multiply, then classify the trend
    // ------------------------------------------------------------------
    always_comb begin
        avg_prod = AVG_PW'(sum_reg) * AVG_PW'(RECIP_W'(RECIP));
        avg_next = avg_prod[AVG_K +: TEMP_W];
        t_x10    = (CMP_W'(t3_reg) << 3) + (CMP_W'(t3_reg) << 1);
        avg_x9   = (CMP_W'(avg_next) << 3) + CMP_W'(avg_next);
        avg_x11  = avg_x9 + (CMP_W'(avg_next) << 1);
        if (t_x10 > avg_x11) begin
            trend_next = TREND_RISING;
        end else if (t_x10 < avg_x9) begin
            trend_next = TREND_FALLING;
        end else begin
            trend_next = TREND_STABLE;
        end
    end

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (ld4) begin
            temp_out_reg  <= t3_reg;
            avg_out_reg   <= avg_next;
            trend_out_reg <= trend_next;
        end
    end

    assign m_tvalid = v4_reg;
    assign m_tdata  = {trend_out_reg, avg_out_reg, temp_out_reg};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `TTF_ASSERT_IMPL(a_sum_bound, aclk, aresetn, 1'b1, sum_reg <= SUM_W'(SUM_MAX),
        "running sum exceeds window capacity")
    `TTF_ASSERT_IMPL(a_temp_clamped, aclk, aresetn, v2_reg, t2_reg <= TEMP_MAX,
        "converted temperature outside clamp range")
    `TTF_ASSERT_IMPL(a_avg_bound, aclk, aresetn, m_tvalid, avg_out_reg <= TEMP_MAX,
        "window average above maximum temperature")
    `TTF_ASSERT_IMPL(a_no_false_stall, aclk, aresetn, !s_tready, v0_reg && v1_reg,
        "input stalled while the front stages have room")
    `TTF_ASSERT_NEXT(a_window_head, aclk, aresetn, ld3, window_reg[0] == $past(t2_reg),
        "window head does not hold the sample just loaded")

endmodule

`default_nettype wire
